// ===== src/bqc_pkg.sv =====
// Package for the biquad lowpass/highpass coefficient generator.
// Holds fixed-point constants, the sequencer state type and the CORDIC angle table.
// No dependencies.
package bqc_pkg;

	localparam int FREQ_W = 25;
	localparam int Q_W    = 23;
	localparam int RATE_W = 18;
	localparam int COEF_W = 32;

	localparam logic [33:0] PI_Q30        = 34'd3373259426;
	localparam logic [33:0] HALF_PI_Q30   = 34'd1686629713;
	localparam logic [33:0] CORDIC_GAIN   = 34'd652032874;
	localparam logic [24:0] RAD_PI_Q22    = 25'd13176794;
	localparam logic [36:0] ALPHA_MAX     = 37'h10_0000_0000;

	localparam logic [1:0] REG_FILTER_TYPE = 2'd0;
	localparam logic [1:0] REG_QUALITY     = 2'd1;
	localparam logic [1:0] REG_RATE        = 2'd2;
	localparam logic [1:0] REG_RADIANS     = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WDIV,
		ST_CORDIC,
		ST_ADIV,
		ST_C0,
		ST_C1,
		ST_C3,
		ST_C4,
		ST_OUT
	} state_t;

	// control from sequencer to divider
	typedef struct packed {
		logic start;
	} div_ctl_t;

	// atan(2^-i) in Q30, rounded
	function automatic logic [31:0] atan_q30(input logic [5:0] i);
		case (i)
			6'd0: atan_q30 = 32'd843314857;
			6'd1: atan_q30 = 32'd497837829;
			6'd2: atan_q30 = 32'd263043837;
			6'd3: atan_q30 = 32'd133525159;
			6'd4: atan_q30 = 32'd67021687;
			6'd5: atan_q30 = 32'd33543516;
			6'd6: atan_q30 = 32'd16775851;
			6'd7: atan_q30 = 32'd8388437;
			6'd8: atan_q30 = 32'd4194283;
			6'd9: atan_q30 = 32'd2097149;
			6'd10: atan_q30 = 32'd1048576;
			6'd11: atan_q30 = 32'd524288;
			6'd12: atan_q30 = 32'd262144;
			6'd13: atan_q30 = 32'd131072;
			6'd14: atan_q30 = 32'd65536;
			6'd15: atan_q30 = 32'd32768;
			6'd16: atan_q30 = 32'd16384;
			6'd17: atan_q30 = 32'd8192;
			6'd18: atan_q30 = 32'd4096;
			6'd19: atan_q30 = 32'd2048;
			6'd20: atan_q30 = 32'd1024;
			6'd21: atan_q30 = 32'd512;
			6'd22: atan_q30 = 32'd256;
			6'd23: atan_q30 = 32'd128;
			6'd24: atan_q30 = 32'd64;
			6'd25: atan_q30 = 32'd32;
			6'd26: atan_q30 = 32'd16;
			6'd27: atan_q30 = 32'd8;
			6'd28: atan_q30 = 32'd4;
			6'd29: atan_q30 = 32'd2;
			6'd30: atan_q30 = 32'd1;
			6'd31: atan_q30 = 32'd0;
			default: atan_q30 = 32'd0;
		endcase
	endfunction

endpackage

// ===== src/bqc_div.sv =====
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on bqc_pkg for the control struct.
module bqc_div #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 40
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bqc_pkg::div_ctl_t       ctl,
	input  logic [NUM_W-1:0]        num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic [NUM_W-1:0]        quo
);
	import bqc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   r_sh;
	logic [DEN_W:0]   r_sub;
	logic             ge;

	assign r_sh  = {r_q, q_q[NUM_W-1]};
	assign ge    = r_sh >= {1'b0, den};
	assign r_sub = ge ? r_sh - {1'b0, den} : r_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below den, so its top bit is always zero
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			q_q <= num;
			r_q <= '0;
		end else if (busy_q) begin
			q_q <= {q_q[NUM_W-2:0], ge};
			r_q <= r_sub[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

// ===== src/biquad_lowpass_highpass_coeffs.sv =====
// Top level of the biquad lowpass/highpass coefficient generator.
// Depends on bqc_pkg and bqc_div.
//
// Use: one word on the input channel (action, frequency) is taken when
// in_valid is high and in_stall low. action 0 stores a new cutoff and
// computes; action 1 recomputes from the stored cutoff. A new cutoff above
// rate/2 (Hz mode) or pi (radians mode) is dropped with no output word.
// Each computation yields one word of five Q3.(COEF_FRAC_BITS) coefficients
// on the output channel, held under out_stall until taken.
// Sequence: a 72-step divide for w (Hz mode), CORDIC_STEPS rotation steps,
// a 72-step divide for alpha and four 72-step coefficient divides, all on
// one shared serial divider. The w divide is skipped in radians mode or at
// a zero sample rate. The block takes no new word until its output word has
// been accepted.
// Reset: registers return to lowpass, Q = 0.7071, 44100 Hz, Hz mode, stored
// cutoff zero; the output channel is empty.
// Configuration: write while idle via cfg_we, cfg_index, cfg_data.
module biquad_lowpass_highpass_coeffs #(
	parameter int COEF_FRAC_BITS = 28,
	parameter int CORDIC_STEPS   = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [22:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [24:0] frequency,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] coef_b0,
	output logic signed [31:0] coef_b1,
	output logic signed [31:0] coef_b2,
	output logic signed [31:0] coef_a1,
	output logic signed [31:0] coef_a2
);
	import bqc_pkg::*;

	localparam int SW = $clog2(CORDIC_STEPS + 1);

	logic        ftype_q, rad_q;
	logic [22:0] qf_q;
	logic [17:0] rate_q;
	logic [24:0] sfreq_q;
	state_t      st_q, st_d;

	logic signed [35:0] x_q, y_q, z_q;
	logic [SW-1:0]      it_q;
	logic               flip_q;
	logic signed [33:0] c_q;
	logic [30:0]        s_q;
	logic [36:0]        alpha_q;
	logic signed [31:0] b0_q, b1_q, a1_q, a2_q;
	logic               ovalid_q;

	logic [71:0] dnum;
	logic [39:0] dden;
	logic        dstart;
	logic        ddone;
	logic [71:0] dquo;
	div_ctl_t    dctl;

	logic accept, ok;
	logic [24:0] f_use;

	assign in_stall = (st_q != ST_IDLE) || ovalid_q;
	assign accept   = in_valid && !in_stall;
	assign ok = action || (rad_q ? (frequency <= RAD_PI_Q22)
	                             : ({7'd0, frequency} <= {7'd0, rate_q, 7'd0}));
	assign f_use = action ? sfreq_q : frequency;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ftype_q <= 1'b0;
			qf_q    <= 23'd46341;
			rate_q  <= 18'd44100;
			rad_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILTER_TYPE: ftype_q <= cfg_data[0];
				REG_QUALITY:     qf_q    <= cfg_data;
				REG_RATE:        rate_q  <= cfg_data[17:0];
				REG_RADIANS:     rad_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// divide operands for each phase
	logic [33:0] one_pc;
	logic [36:0] mag_num;
	logic        num_neg;
	logic [38:0] a0;
	logic [22:0] q_eff;
	assign a0    = 39'(alpha_q) + 39'h4000_0000;
	assign q_eff = (qf_q == '0) ? 23'd1 : qf_q;

	always_comb begin
		one_pc  = ftype_q ? 34'(34'sh4000_0000 + c_q) : 34'(34'sh4000_0000 - c_q);
		mag_num = 37'(one_pc);
		num_neg = ftype_q;
		case (st_q)
			ST_C3: begin
				num_neg = !c_q[33];
				mag_num = c_q[33] ? 37'(-(c_q <<< 1)) : 37'(c_q <<< 1);
			end
			ST_C4: begin
				num_neg = alpha_q > 37'h4000_0000;
				mag_num = num_neg ? 37'(alpha_q - 37'h4000_0000)
				                  : 37'(37'h4000_0000 - alpha_q);
			end
			ST_C0: num_neg = 1'b0;
			default: ;
		endcase
	end

	// quotient to coefficient: rounding to COEF_FRAC_BITS, then saturation
	localparam int SH = 34 - COEF_FRAC_BITS;
	logic [71:0] q_int;
	logic [33:0] q_r;
	logic [31:0] coef;
	always_comb begin
		q_int = dquo >> SH;
		if (q_int >= (72'd1 << (COEF_FRAC_BITS + 4)))
			q_r = 34'h0_8000_0000;
		else
			q_r = 34'((q_int + 72'd1) >> 1);
		if (num_neg)
			coef = (q_r > 34'h0_8000_0000) ? 32'h8000_0000 : 32'(-q_r);
		else
			coef = (q_r > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q_r[31:0];
	end

	always_comb begin
		dnum = '0;
		dden = 40'd1;
		case (st_q)
			ST_WDIV: begin
				dnum = 72'(sfreq_q) * 72'(PI_Q30) + 72'({rate_q, 6'd0});
				dden = 40'({rate_q, 7'd0});
			end
			ST_ADIV: begin
				dnum = 72'({s_q, 15'd0}) + 72'(q_eff >> 1);
				dden = 40'(q_eff);
			end
			ST_C0: begin
				dnum = 72'(mag_num) << 35;
				dden = 40'({a0, 1'b0});
			end
			default: begin
				dnum = 72'(mag_num) << 35;
				dden = 40'(a0);
			end
		endcase
	end

	assign dctl.start = dstart;

	bqc_div #(.NUM_W(72), .DEN_W(40)) u_div (
		.clk, .arst_n, .ctl(dctl), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo)
	);

	logic div_busy_q;
	assign dstart = !div_busy_q && (st_q == ST_WDIV || st_q == ST_ADIV ||
	                st_q == ST_C0 || st_q == ST_C1 || st_q == ST_C3 || st_q == ST_C4);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (accept && ok) st_d = (rad_q || rate_q == '0) ? ST_CORDIC : ST_WDIV;
			ST_WDIV: if (ddone) st_d = ST_CORDIC;
			ST_CORDIC: if (it_q == SW'(CORDIC_STEPS)) st_d = ST_ADIV;
			ST_ADIV: if (ddone) st_d = ST_C0;
			ST_C0: if (ddone) st_d = ST_C1;
			ST_C1: if (ddone) st_d = ST_C3;
			ST_C3: if (ddone) st_d = ST_C4;
			ST_C4: if (ddone) st_d = ST_OUT;
			ST_OUT: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// w set from the divider or from the radian input, folded into [0, pi/2]
	logic [33:0] w_new, w_sat;
	logic signed [35:0] dx, dy;
	logic signed [35:0] xc, yc;
	always_comb begin
		w_new = (st_q == ST_WDIV) ? ((dquo > 72'(PI_Q30)) ? PI_Q30 : 34'(dquo)) :
		        (rad_q ? 34'({f_use, 8'd0}) : 34'd0);
		w_sat = (w_new > PI_Q30) ? PI_Q30 : w_new;
		dx = y_q >>> it_q;
		dy = x_q >>> it_q;
		xc = (x_q > 36'sh4000_0000) ? 36'sh4000_0000 :
		     (x_q < -36'sh4000_0000) ? -36'sh4000_0000 : x_q;
		yc = (y_q > 36'sh4000_0000) ? 36'sh4000_0000 :
		     (y_q < 0) ? 36'sh0 : y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			ovalid_q   <= 1'b0;
			sfreq_q    <= '0;
			div_busy_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (dstart) div_busy_q <= 1'b1;
			else if (ddone) div_busy_q <= 1'b0;
			if (accept && ok && !action) sfreq_q <= frequency;
			if (st_q == ST_OUT) ovalid_q <= 1'b1;
			else if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == ST_IDLE && st_d == ST_CORDIC) || (st_q == ST_WDIV && ddone)) begin
			flip_q <= w_sat > HALF_PI_Q30;
			z_q    <= (w_sat > HALF_PI_Q30) ? 36'(PI_Q30 - w_sat) : 36'(w_sat);
			x_q    <= 36'(CORDIC_GAIN);
			y_q    <= '0;
			it_q   <= '0;
		end else if (st_q == ST_CORDIC && it_q != SW'(CORDIC_STEPS)) begin
			it_q <= it_q + 1'b1;
			if (!z_q[35]) begin
				x_q <= x_q - dx; y_q <= y_q + dy;
				z_q <= z_q - 36'(atan_q30(6'(it_q)));
			end else begin
				x_q <= x_q + dx; y_q <= y_q - dy;
				z_q <= z_q + 36'(atan_q30(6'(it_q)));
			end
		end
		if (st_q == ST_CORDIC && st_d == ST_ADIV) begin
			c_q <= flip_q ? 34'(-xc) : 34'(xc);
			s_q <= 31'(yc);
		end
		if (st_q == ST_ADIV && ddone)
			alpha_q <= (dquo > 72'(ALPHA_MAX)) ? ALPHA_MAX : 37'(dquo);
		if (ddone && st_q == ST_C0) b0_q <= coef;
		if (ddone && st_q == ST_C1) b1_q <= coef;
		if (ddone && st_q == ST_C3) a1_q <= coef;
		if (ddone && st_q == ST_C4) a2_q <= coef;
	end

	assign out_valid = ovalid_q;
	assign coef_b0   = b0_q;
	assign coef_b1   = b1_q;
	assign coef_b2   = b0_q;
	assign coef_a1   = a1_q;
	assign coef_a2   = a2_q;

endmodule
